// ----- sv/u8u2_pkg.sv -----
// u8u2_pkg: types and constants shared by the utf-8 to 16-bit decoder
// no dependencies; compiled first

package u8u2_pkg;

   // utf-8 byte classes: mask and tag pairs
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;

   // byte count saturation
   localparam logic [15:0] TOTAL_SAT_LIMIT = 16'd65533;
   localparam logic [15:0] TOTAL_MAX       = 16'hFFFF;
   localparam logic [15:0] UNIT_BYTES      = 16'd2;

   // pending continuation counts
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_THREE = 2'd3;

   // register map
   localparam int         CSR_ADDR_W     = 3;
   localparam logic       CSR_BIG_ENDIAN = 1'b0;
   localparam logic       BIG_ENDIAN_RST = 1'b1;

   typedef struct packed {
      logic [1:0]  pending_count;
      logic [15:0] code_bits;
      logic        error_hold;
      logic [15:0] byte_total;
   } state_type;

   typedef struct packed {
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic        code_error;
      logic [15:0] bytes_written;
   } result_type;

endpackage

// ----- sv/u8u2_req_if.sv -----
// u8u2_req_if: input byte channel of the decoder
// no dependencies

interface u8u2_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last;

   modport source (output valid, output in_byte, output last, input ready);
   modport sink   (input valid, input in_byte, input last, output ready);
endinterface

// ----- sv/u8u2_rsp_if.sv -----
// u8u2_rsp_if: result channel of the decoder
// no dependencies

interface u8u2_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  first_byte;
   logic [7:0]  second_byte;
   logic        code_error;
   logic [15:0] bytes_written;

   modport source (output valid, output first_byte, output second_byte,
                   output code_error, output bytes_written, input ready);
   modport sink   (input valid, input first_byte, input second_byte,
                   input code_error, input bytes_written, output ready);
endinterface

// ----- sv/u8u2_step.sv -----
// u8u2_step: per-byte decode step, next state and optional result
// depends on u8u2_pkg

module u8u2_step (
   input  u8u2_pkg::state_type  state_ff,
   input  logic [7:0]           in_byte,
   input  logic                 last,
   input  logic                 big_endian,
   output u8u2_pkg::state_type  state_in,
   output logic                 emit,
   output u8u2_pkg::result_type result
);
   import u8u2_pkg::*;

   logic [15:0] total_inc;
   logic [15:0] cont_bits;
   logic [15:0] unit_bits;
   logic [1:0]  pend_dec;
   logic        is_unit;
   logic        is_error;

   assign total_inc = (state_ff.byte_total >= TOTAL_SAT_LIMIT) ? TOTAL_MAX
                      : state_ff.byte_total + UNIT_BYTES;
   assign cont_bits = {state_ff.code_bits[9:0], in_byte[5:0]};
   assign pend_dec  = state_ff.pending_count - PEND_ONE;

   always_comb begin
      state_in  = state_ff;
      is_unit   = 1'b0;
      is_error  = 1'b0;
      unit_bits = '0;
      if (state_ff.error_hold) begin
         if (in_byte == 8'h00) begin
            state_in = '0;
         end
      end else if (state_ff.pending_count == PEND_NONE) begin
         if (in_byte == 8'h00) begin
            state_in = '0;
         end else if ((in_byte & ASCII_MASK) == 8'h00) begin
            is_unit   = 1'b1;
            unit_bits = {8'h00, in_byte};
         end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
            state_in.code_bits     = {11'd0, in_byte[4:0]};
            state_in.pending_count = PEND_ONE;
         end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
            state_in.code_bits     = {12'd0, in_byte[3:0]};
            state_in.pending_count = PEND_TWO;
         end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
            state_in.code_bits     = {13'd0, in_byte[2:0]};
            state_in.pending_count = PEND_THREE;
         end else begin
            is_error = 1'b1;
         end
      end else begin
         if ((in_byte & CONT_MASK) == CONT_TAG) begin
            state_in.pending_count = pend_dec;
            if (pend_dec == PEND_NONE) begin
               is_unit   = 1'b1;
               unit_bits = cont_bits;
            end else begin
               state_in.code_bits = cont_bits;
            end
         end else begin
            is_error = 1'b1;
         end
      end

      if (is_unit) begin
         state_in.code_bits  = '0;
         state_in.byte_total = total_inc;
      end
      if (is_error) begin
         state_in.error_hold    = 1'b1;
         state_in.pending_count = PEND_NONE;
         state_in.code_bits     = '0;
         if (in_byte == 8'h00) begin
            state_in = '0;
         end
      end
      // end of string
      if (last) begin
         state_in = '0;
      end
   end

   always_comb begin
      result = '0;
      if (is_unit) begin
         result.first_byte    = big_endian ? unit_bits[15:8] : unit_bits[7:0];
         result.second_byte   = big_endian ? unit_bits[7:0] : unit_bits[15:8];
         result.bytes_written = total_inc;
      end else begin
         result.code_error    = 1'b1;
         result.bytes_written = state_ff.byte_total;
      end
   end

   assign emit = is_unit | is_error;

endmodule

// ----- sv/utf8_to_ucs2_decoder_unit.sv -----
// Decodes a stream of utf-8 bytes, one per transfer, into 16-bit code units. Each
// byte enters an input register and is decoded into a result register when that
// register is empty or being read, so one byte can be taken every cycle while the
// output is not stalled; req.ready falls only while the result register is full and
// rsp.ready is low. Four-byte sequences keep the low 16 bits of the code point. A bad
// byte gives one error result with zero bytes, then bytes are dropped until a zero
// byte or a transfer with last set ends the string. Register 0 (byte address 0,
// bit 0, reset 1) selects high byte first.

module utf8_to_ucs2_decoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   u8u2_req_if.sink                           req,
   u8u2_rsp_if.source                         rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [u8u2_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import u8u2_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   state_type  state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       big_endian_ff, big_endian_in;
   logic       advance;
   logic       req_xfer;
   logic       emit;
   result_type result;
   logic       csr_hit;

   u8u2_step u_step (
      .state_ff   (state_ff),
      .in_byte    (in_byte_ff),
      .last       (in_last_ff),
      .big_endian (big_endian_ff),
      .state_in   (state_in),
      .emit       (emit),
      .result     (result)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | rsp.ready);
   assign req.ready = ~in_valid_ff | advance;
   assign req_xfer  = req.valid & req.ready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance ? emit : (out_valid_ff & ~rsp.ready);

   // register port
   assign csr_hit       = (paddr[CSR_ADDR_W-1] == CSR_BIG_ENDIAN);
   assign big_endian_in = (psel & penable & pwrite & csr_hit) ? pwdata[0] : big_endian_ff;
   assign pready        = 1'b1;
   assign prdata        = csr_hit ? {31'd0, big_endian_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         big_endian_ff <= BIG_ENDIAN_RST;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         big_endian_ff <= big_endian_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req.in_byte;
         in_last_ff <= req.last;
      end
      if (advance & emit) begin
         out_ff <= result;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.first_byte    = out_ff.first_byte;
   assign rsp.second_byte   = out_ff.second_byte;
   assign rsp.code_error    = out_ff.code_error;
   assign rsp.bytes_written = out_ff.bytes_written;

endmodule

// ----- sv/u8u2_checker.sv -----
// u8u2_checker: port-level assertions on the decoder, bound to the top level
// depends on utf8_to_ucs2_decoder_unit and its interfaces

module u8u2_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_first_byte,
   input logic [7:0]  rsp_second_byte,
   input logic        rsp_code_error,
   input logic [15:0] rsp_bytes_written
);

   // stalled result transfer holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_first_byte)
         && $stable(rsp_second_byte) && $stable(rsp_code_error)
         && $stable(rsp_bytes_written))
      else $error("result changed while stalled");

   // error results carry zero bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code_error |-> rsp_first_byte == 8'h00 && rsp_second_byte == 8'h00)
      else $error("error result with non-zero bytes");

   // good results count in whole code units or saturate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_code_error |-> rsp_bytes_written != 16'd0
         && (rsp_bytes_written[0] == 1'b0 || rsp_bytes_written == 16'hFFFF))
      else $error("bad byte count on good result");

   // nothing offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind utf8_to_ucs2_decoder_unit u8u2_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_first_byte    (rsp.first_byte),
   .rsp_second_byte   (rsp.second_byte),
   .rsp_code_error    (rsp.code_error),
   .rsp_bytes_written (rsp.bytes_written)
);
